@@ rtl/core/alid_pkg.sv @@
package alid_pkg;

    // request kind carried on s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // width of one list word
    localparam int WORD_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DEL_CAP,
        ST_SHIFT,
        ST_WR_VAL,
        ST_DONE
    } t_state;

endpackage

@@ rtl/core/array_list_insert_delete_core.sv @@
// channel | dir | tdata fields, lowest bit up           | tuser
// s_*     | in  | position, value, zero pad to bytes     | operation
// m_*     | out | ok, removed_value, count_after, pad    | none
//
// a request is decided, a delete captures the removed word, the tail of the
// list is moved one entry per cycle through the list memory (one read port,
// one write port, registered read data), an insert then writes the new
// value, and the result is loaded; a rejected request goes straight from the
// decision to the result. A delete moves length - position entries, an
// insert length - position + 1.
// reset clears the length and the output valid, the list memory is not cleared.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register while the next request is accepted, and the sequencer
// holds in its last state while that register is still occupied.
module array_list_insert_delete_core
    import alid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // position, value, zero pad
    input  logic [((($clog2(CAPACITY + 2) + 32) + 7) / 8) * 8 - 1:0] s_tdata,
    // operation
    input  logic           s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // ok, removed_value, count_after, zero pad
    output logic [(((1 + 32 + $clog2(CAPACITY + 1)) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int PW  = $clog2(CAPACITY + 2);
    localparam int OUT_BITS = 1 + WORD_W + LW;
    localparam int OW  = ((OUT_BITS + 7) / 8) * 8;

    // list memory
    logic [WORD_W-1:0] mem [CAPACITY];

    t_state            r_state, n_state;
    logic              r_op;
    logic [PW-1:0]     r_pos;
    logic [WORD_W-1:0] r_value;
    logic [LW-1:0]     r_length, n_length;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_pend, n_pend;
    logic [WORD_W-1:0] r_removed, n_removed;
    logic              r_ok, n_ok;
    logic [WORD_W-1:0] r_rdata;
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok;
    logic [WORD_W-1:0] r_out_removed;
    logic [LW-1:0]     r_out_count;

    logic              mem_re, mem_we;
    logic [AW-1:0]     mem_ra, mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              in_fire, out_load, out_free;

    logic [PW-1:0]     len_ext, pos_m1;
    logic [LW-1:0]     len_m1, len_p1, ins_cnt, del_cnt;
    logic              pos_nz, ins_ok, del_ok;

    // request checks
    assign len_ext = PW'(r_length);
    assign pos_m1  = r_pos - PW'(1);
    assign len_m1  = r_length - LW'(1);
    assign len_p1  = r_length + LW'(1);
    assign ins_cnt = r_length - LW'(pos_m1);
    assign del_cnt = r_length - LW'(r_pos);
    assign pos_nz  = (r_pos != '0);
    assign ins_ok  = (r_op == OP_INSERT) && pos_nz && (r_pos <= len_ext + PW'(1))
                     && (r_length < LW'(CAPACITY));
    assign del_ok  = (r_op == OP_DELETE) && pos_nz && (r_pos <= len_ext);

    // handshakes
    assign s_tready = (r_state == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = OW'({r_out_count, r_out_removed, r_out_ok});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (ins_ok) n_state = ST_SHIFT;
                else if (del_ok)     n_state = ST_DEL_CAP;
                else                 n_state = ST_DONE;
            end
            ST_DEL_CAP: n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (r_cnt == '0 && !r_pend) begin
                    n_state = (r_op == OP_INSERT) ? ST_WR_VAL : ST_DONE;
                end
            end
            ST_WR_VAL: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control and memory port
    always_comb begin
        n_length    = r_length;
        n_cnt       = r_cnt;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_pend      = r_pend;
        n_removed   = r_removed;
        n_ok        = r_ok;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_ra      = r_rd_addr;
        mem_wa      = r_wr_addr;
        mem_wd      = r_rdata;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_DECIDE: begin
                n_removed = '0;
                n_pend    = 1'b0;
                priority if (ins_ok) begin
                    n_ok      = 1'b1;
                    n_length  = len_p1;
                    n_cnt     = ins_cnt;
                    n_rd_addr = len_m1[AW-1:0];
                    n_wr_addr = r_length[AW-1:0];
                end else if (del_ok) begin
                    // fetch the word being removed
                    n_ok      = 1'b1;
                    n_length  = len_m1;
                    n_cnt     = del_cnt;
                    mem_re    = 1'b1;
                    mem_ra    = pos_m1[AW-1:0];
                    n_rd_addr = r_pos[AW-1:0];
                    n_wr_addr = pos_m1[AW-1:0];
                end else begin
                    n_ok = 1'b0;
                end
            end
            ST_DEL_CAP: n_removed = r_rdata;
            ST_SHIFT: begin
                // read one entry ahead, write the previous read one slot over
                if (r_cnt != '0) begin
                    mem_re    = 1'b1;
                    mem_ra    = r_rd_addr;
                    n_rd_addr = (r_op == OP_INSERT) ? r_rd_addr - AW'(1)
                                                    : r_rd_addr + AW'(1);
                    n_cnt     = r_cnt - LW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_wa    = r_wr_addr;
                    mem_wd    = r_rdata;
                    n_wr_addr = (r_op == OP_INSERT) ? r_wr_addr - AW'(1)
                                                    : r_wr_addr + AW'(1);
                end
            end
            ST_WR_VAL: begin
                mem_we = 1'b1;
                mem_wa = pos_m1[AW-1:0];
                mem_wd = r_value;
            end
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (out_load)  n_out_valid = 1'b1;
        else if (m_tready)      n_out_valid = 1'b0;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_tuser;
            r_pos   <= s_tdata[PW-1:0];
            r_value <= s_tdata[PW+WORD_W-1:PW];
        end
        r_cnt     <= n_cnt;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_pend    <= n_pend;
        r_removed <= n_removed;
        r_ok      <= n_ok;
        if (out_load) begin
            r_out_ok      <= r_ok;
            r_out_removed <= r_removed;
            r_out_count   <= r_length;
        end
    end

    // list memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

endmodule

@@ rtl/core/alid_checker.sv @@
module alid_checker
    import alid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    // ok, removed_value, count_after, zero pad
    input logic [(((1 + 32 + $clog2(CAPACITY + 1)) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int LW = $clog2(CAPACITY + 1);

    // the block is busy in the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an input transaction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a rejected request never reports a removed word
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[WORD_W:1] == '0)
        else $error("rejected request with nonzero removed_value");

    // the length never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[WORD_W+LW:WORD_W+1] <= LW'(CAPACITY))
        else $error("count_after above capacity");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind array_list_insert_delete_core alid_checker #(.CAPACITY(CAPACITY)) u_alid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
